// File: sv/rlfs_pkg.sv
// Shared types and constants of the RGB LED frame serializer.
`default_nettype none
package rlfs_pkg;

  localparam int PIXEL_COUNT_DEF = 8;
  localparam int COLOR_W = 24;
  localparam int TICK_W = 12;
  localparam int BIT_POS_W = 5;
  localparam logic [BIT_POS_W-1:0] LAST_BIT = BIT_POS_W'(COLOR_W - 1);
  localparam int IDX_CMP_W = 11;

  localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 12'd5;
  localparam logic [TICK_W-1:0] ONE_HIGH_RST = 12'd20;
  localparam logic [TICK_W-1:0] PERIOD_RST = 12'd25;
  localparam logic [TICK_W-1:0] LATCH_RST = 12'd600;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_FILL  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SEND  = 2'd1,
    PH_LATCH = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_ZERO_HIGH = 2'd0,
    REG_ONE_HIGH  = 2'd1,
    REG_PERIOD    = 2'd2,
    REG_LATCH     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                 rotate;
    logic                 wr;
    logic                 clr;
    logic                 fill;
    logic [7:0]           idx;
    logic [COLOR_W-1:0]   color;
  } cell_ctrl_t;

  typedef struct packed {
    logic level;
    logic busy;
    logic done;
  } seq_out_t;

  typedef struct packed {
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] latch;
  } timing_t;

endpackage
`default_nettype wire

// File: sv/rgb_led_frame_serializer_top.sv
// Top level of the RGB LED frame serializer: stream ports, registers, cell chain.
//
// One command is taken per clock cycle unless the result port stalls, and its result
// is registered for the next cycle; a tick advances the line waveform by one step.
// Colors sit in a ring of PIXEL_COUNT cells that rotates by one cell after each 24-bit
// pixel goes out, so the frame reads only cells 0 and 1 and ends with the ring in order.
`default_nettype none
module rgb_led_frame_serializer_top #(
  parameter int PIXEL_COUNT = rlfs_pkg::PIXEL_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // command[1:0], pixel_index[9:2], red[17:10], green[25:18], blue[33:26], zero pad
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // line_level[0], busy_res[1], status[3:2], frame_done[4], zero pad
  output logic [7:0]       m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  rlfs_pkg::cmd_t                       cmd;
  logic [7:0]                           pix_idx;
  logic [7:0]                           red, green, blue;
  logic                                 accept, is_tick, in_range, do_write;
  logic                                 rotate;
  rlfs_pkg::status_t                    status;
  rlfs_pkg::timing_t                    timing;
  rlfs_pkg::cell_ctrl_t                 ctrl;
  rlfs_pkg::phase_t                     phase;
  rlfs_pkg::seq_out_t                   so;
  rlfs_pkg::reg_idx_t                   reg_sel;
  logic [rlfs_pkg::COLOR_W-1:0]         cell_val [PIXEL_COUNT];
  logic [rlfs_pkg::COLOR_W-1:0]         cell_val_next [PIXEL_COUNT];

  assign cmd = rlfs_pkg::cmd_t'(s_tdata[1:0]);
  assign pix_idx = s_tdata[9:2];
  assign red = s_tdata[17:10];
  assign green = s_tdata[25:18];
  assign blue = s_tdata[33:26];

  assign s_tready = !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;
  assign is_tick = (cmd == rlfs_pkg::CMD_TICK);
  assign in_range = ({3'b000, pix_idx} < rlfs_pkg::IDX_CMP_W'(PIXEL_COUNT));

  always_comb begin
    status = rlfs_pkg::ST_OK;
    do_write = 1'b0;
    priority if (is_tick) begin
      status = rlfs_pkg::ST_OK;
    end else if (phase != rlfs_pkg::PH_IDLE) begin
      status = rlfs_pkg::ST_BUSY;
    end else if (cmd != rlfs_pkg::CMD_FILL && !in_range) begin
      status = rlfs_pkg::ST_RANGE;
    end else begin
      do_write = 1'b1;
    end
  end

  always_comb begin
    ctrl.rotate = rotate;
    ctrl.wr = accept && do_write;
    ctrl.clr = (cmd == rlfs_pkg::CMD_CLEAR);
    ctrl.fill = (cmd == rlfs_pkg::CMD_FILL);
    ctrl.idx = pix_idx;
    ctrl.color = {green, red, blue};
  end

  for (genvar i = 0; i < PIXEL_COUNT; i++) begin : g_cell
    rlfs_cell #(
      .INDEX(i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (accept),
      .ctrl       (ctrl),
      .neighbor   (cell_val[(i + 1) % PIXEL_COUNT]),
      .value      (cell_val[i]),
      .value_next (cell_val_next[i])
    );
  end

  rlfs_seq #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .adv         (accept && is_tick),
    .start       (accept && do_write),
    .timing      (timing),
    .first_color (cell_val_next[0]),
    .next_color  (cell_val[1 % PIXEL_COUNT]),
    .phase       (phase),
    .so          (so),
    .rotate      (rotate)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, so.done, status, so.busy, so.level};
    end
  end

  assign reg_sel = rlfs_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.zero_high <= rlfs_pkg::ZERO_HIGH_RST;
      timing.one_high <= rlfs_pkg::ONE_HIGH_RST;
      timing.period <= rlfs_pkg::PERIOD_RST;
      timing.latch <= rlfs_pkg::LATCH_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        rlfs_pkg::REG_ZERO_HIGH: timing.zero_high <= pwdata[rlfs_pkg::TICK_W-1:0];
        rlfs_pkg::REG_ONE_HIGH:  timing.one_high <= pwdata[rlfs_pkg::TICK_W-1:0];
        rlfs_pkg::REG_PERIOD:    timing.period <= pwdata[rlfs_pkg::TICK_W-1:0];
        rlfs_pkg::REG_LATCH:     timing.latch <= pwdata[rlfs_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      rlfs_pkg::REG_ZERO_HIGH: prdata = {20'd0, timing.zero_high};
      rlfs_pkg::REG_ONE_HIGH:  prdata = {20'd0, timing.one_high};
      rlfs_pkg::REG_PERIOD:    prdata = {20'd0, timing.period};
      rlfs_pkg::REG_LATCH:     prdata = {20'd0, timing.latch};
      default:                 prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/rlfs_cell.sv
// One pixel cell of the rotating color chain.
`default_nettype none
module rlfs_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire rlfs_pkg::cell_ctrl_t           ctrl,
  input  wire logic [rlfs_pkg::COLOR_W-1:0]   neighbor,
  output logic      [rlfs_pkg::COLOR_W-1:0]   value,
  output logic      [rlfs_pkg::COLOR_W-1:0]   value_next
);

  logic hit;

  assign hit = ({3'b000, ctrl.idx} == rlfs_pkg::IDX_CMP_W'(INDEX));

  always_comb begin
    value_next = value;
    if (ctrl.rotate) begin
      value_next = neighbor;
    end else if (ctrl.wr) begin
      if (ctrl.fill || hit) begin
        value_next = ctrl.color;
      end else if (ctrl.clr) begin
        value_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (en) begin
      value <= value_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/rlfs_seq.sv
// Bit, pixel and latch sequencer that shapes the line waveform.
`default_nettype none
module rlfs_seq #(
  parameter int PIXEL_COUNT = rlfs_pkg::PIXEL_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           adv,
  input  wire logic                           start,
  input  wire rlfs_pkg::timing_t              timing,
  input  wire logic [rlfs_pkg::COLOR_W-1:0]   first_color,
  input  wire logic [rlfs_pkg::COLOR_W-1:0]   next_color,
  output rlfs_pkg::phase_t                    phase,
  output rlfs_pkg::seq_out_t                  so,
  output logic                                rotate
);

  localparam int PW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam logic [PW-1:0] LAST_PIX = PW'(PIXEL_COUNT - 1);

  rlfs_pkg::phase_t                     phase_next;
  logic [PW-1:0]                        pix_pos, pix_pos_next;
  logic [rlfs_pkg::BIT_POS_W-1:0]       bit_pos, bit_pos_next;
  logic [rlfs_pkg::TICK_W-1:0]          tick_cnt, tick_cnt_next;
  logic [rlfs_pkg::COLOR_W-1:0]         shift_word, shift_word_next;
  logic [rlfs_pkg::TICK_W:0]            tick_inc;
  logic                                 bit_end, latch_end, pix_end;
  logic [rlfs_pkg::TICK_W-1:0]          high_ticks;

  assign tick_inc = {1'b0, tick_cnt} + 1'b1;
  assign bit_end = tick_inc[rlfs_pkg::TICK_W] ||
                   (tick_inc[rlfs_pkg::TICK_W-1:0] >= timing.period);
  assign latch_end = tick_inc[rlfs_pkg::TICK_W] ||
                     (tick_inc[rlfs_pkg::TICK_W-1:0] >= timing.latch);
  assign pix_end = bit_end && (bit_pos == rlfs_pkg::LAST_BIT);

  always_comb begin
    phase_next = phase;
    pix_pos_next = pix_pos;
    bit_pos_next = bit_pos;
    tick_cnt_next = tick_cnt;
    shift_word_next = shift_word;
    if (start) begin
      phase_next = rlfs_pkg::PH_SEND;
      pix_pos_next = '0;
      bit_pos_next = '0;
      tick_cnt_next = '0;
      shift_word_next = first_color;
    end else if (adv) begin
      unique case (phase)
        rlfs_pkg::PH_SEND: begin
          if (bit_end) begin
            tick_cnt_next = '0;
            shift_word_next = {shift_word[rlfs_pkg::COLOR_W-2:0], 1'b0};
            if (pix_end) begin
              bit_pos_next = '0;
              if (pix_pos == LAST_PIX) begin
                pix_pos_next = '0;
                shift_word_next = '0;
                phase_next = rlfs_pkg::PH_LATCH;
              end else begin
                pix_pos_next = pix_pos + 1'b1;
                shift_word_next = next_color;
              end
            end else begin
              bit_pos_next = bit_pos + 1'b1;
            end
          end else begin
            tick_cnt_next = tick_inc[rlfs_pkg::TICK_W-1:0];
          end
        end
        rlfs_pkg::PH_LATCH: begin
          if (latch_end) begin
            tick_cnt_next = '0;
            phase_next = rlfs_pkg::PH_IDLE;
          end else begin
            tick_cnt_next = tick_inc[rlfs_pkg::TICK_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign high_ticks = shift_word_next[rlfs_pkg::COLOR_W-1] ? timing.one_high : timing.zero_high;

  assign rotate = adv && (phase == rlfs_pkg::PH_SEND) && pix_end;

  always_comb begin
    so.level = (phase_next == rlfs_pkg::PH_SEND) && (tick_cnt_next < high_ticks);
    so.busy = (phase_next != rlfs_pkg::PH_IDLE);
    so.done = adv && (phase == rlfs_pkg::PH_LATCH) && latch_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= rlfs_pkg::PH_IDLE;
      pix_pos <= '0;
      bit_pos <= '0;
      tick_cnt <= '0;
      shift_word <= '0;
    end else if (adv || start) begin
      phase <= phase_next;
      pix_pos <= pix_pos_next;
      bit_pos <= bit_pos_next;
      tick_cnt <= tick_cnt_next;
      shift_word <= shift_word_next;
    end
  end

endmodule
`default_nettype wire
